FILE: rtl/sdpf_pkg.sv
`timescale 1ns / 1ps

package sdpf_pkg;

  // Field and register widths.
  localparam int POS_W   = 32;
  localparam int OUT_W   = 48;
  localparam int IDX_W   = 3;

  // Pipeline depths of the arithmetic units.
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 80;
  localparam int QMUL_LAT   = 2;

  // Divider operand widths.
  localparam int NUM_W = 80;
  localparam int DEN_W = 64;

  // Powers of the inverse distance, Q.30 with a cap at 2^50.
  localparam int POW_W = 51;
  localparam logic [POW_W-1:0] POW_CAP = POW_W'(1) << 50;

  // Largest positive result magnitude, 2^47 - 1.
  localparam logic [46:0] MAX47 = '1;

  // Polynomial coefficients: 0.625201 in Q0.32 and 1.4 in Q1.31.
  localparam logic [31:0] K_CUBE_Q32 = 32'd2685217848;
  localparam logic [31:0] K_LIN_Q31  = 32'd3006477107;

  // Register indices.
  localparam logic [IDX_W-1:0] REG_BOX_LENGTH    = 3'd0;
  localparam logic [IDX_W-1:0] REG_POTENTIAL     = 3'd1;
  localparam logic [IDX_W-1:0] REG_DIAM_SMALL    = 3'd2;
  localparam logic [IDX_W-1:0] REG_DIAM_MIXED    = 3'd3;
  localparam logic [IDX_W-1:0] REG_DIAM_LARGE    = 3'd4;

  // Register reset values.
  localparam logic [31:0] BOX_LENGTH_RST = 32'd2174837221;
  localparam logic [31:0] DIAM_SMALL_RST = 32'd92973830;
  localparam logic [31:0] DIAM_MIXED_RST = 32'd111568596;
  localparam logic [31:0] DIAM_LARGE_RST = 32'd130163362;

  // One stage of the restoring divider.
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] nq;
    logic [DEN_W-1:0] den;
  } div_st_t;

  // One stage of the digit-by-digit square root.
  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] xs;
  } root_st_t;

  // Bring down one numerator bit and subtract where the divisor fits.
  function automatic div_st_t div_step(input div_st_t s);
    logic [DEN_W:0] trial;
    logic           ge;
    div_st_t        o;
    trial = {s.rem, s.nq[NUM_W-1]};
    ge    = (trial >= {1'b0, s.den});
    o.den = s.den;
    o.rem = ge ? DEN_W'(trial - {1'b0, s.den}) : trial[DEN_W-1:0];
    o.nq  = {s.nq[NUM_W-2:0], ge};
    return o;
  endfunction

  // Bring down two radicand bits and settle one root bit.
  function automatic root_st_t root_step(input root_st_t s);
    logic [35:0] trial;
    logic [35:0] cand;
    logic        ge;
    root_st_t    o;
    trial  = {s.rem, s.xs[63:62]};
    cand   = {2'b00, s.root, 2'b01};
    ge     = (trial >= cand);
    o.rem  = ge ? 34'(trial - cand) : trial[33:0];
    o.root = {s.root[30:0], ge};
    o.xs   = {s.xs[61:0], 2'b00};
    return o;
  endfunction

  // Clamp a non-negative value to the positive output range.
  function automatic logic [46:0] sat47(input logic [NUM_W-1:0] x);
    return (x > NUM_W'(MAX47)) ? MAX47 : x[46:0];
  endfunction

endpackage

FILE: rtl/sdpf_sqrt.sv
`timescale 1ns / 1ps

// Pipelined integer square root, one root bit per stage.
module sdpf_sqrt import sdpf_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  root_st_t st [SQRT_STEPS];
  root_st_t seed;

  assign seed = '{rem: '0, root: '0, xs: radicand};

  // Each stage works on the word that the stage before it held.
  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= root_step(seed);
      for (int i = 1; i < SQRT_STEPS; i++) begin
        st[i] <= root_step(st[i-1]);
      end
    end
  end

  assign root = st[SQRT_STEPS-1].root;

endmodule

FILE: rtl/sdpf_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
module sdpf_div import sdpf_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  div_st_t st [DIV_STEPS];
  div_st_t seed;

  assign seed = '{rem: '0, nq: num, den: den};

  // The quotient bits shift in where the numerator bits leave.
  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= div_step(seed);
      for (int i = 1; i < DIV_STEPS; i++) begin
        st[i] <= div_step(st[i-1]);
      end
    end
  end

  assign quo = st[DIV_STEPS-1].nq;

endmodule

FILE: rtl/sdpf_qmul.sv
`timescale 1ns / 1ps

// Q.30 product of two capped powers; an overflow of 64 bits gives the cap.
module sdpf_qmul import sdpf_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [POW_W-1:0] a,
  input  logic [POW_W-1:0] b,
  output logic [POW_W-1:0] y
);

  logic [49:0]  pp_hh;
  logic [50:0]  pp_hl;
  logic [50:0]  pp_lh;
  logic [51:0]  pp_ll;
  logic [101:0] sum;

  // Four partial products on halves of the operands.
  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= a[50:26] * b[50:26];
      pp_hl <= a[50:26] * b[25:0];
      pp_lh <= a[25:0] * b[50:26];
      pp_ll <= a[25:0] * b[25:0];
    end
  end

  assign sum = {pp_hh, 52'b0} + {25'b0, pp_hl, 26'b0} + {25'b0, pp_lh, 26'b0}
             + {50'b0, pp_ll};

  // Recombine and cap.
  always_ff @(posedge clk) begin
    if (en) begin
      y <= (|sum[101:64]) ? POW_CAP : {17'b0, sum[63:30]};
    end
  end

endmodule

FILE: rtl/soft_disk_pair_force_unit.sv
`timescale 1ns / 1ps

// Soft-disk pair force unit.
// The input stream carries one candidate disk pair per word: the two positions
// in tdata and the two size classes in tuser. The output stream gives one word
// per pair: the contact flag in tuser and the force on the second disk, the
// scalar force and the virial in tdata. The configuration port sets the box
// length, the potential and the three contact diameters; write it only while
// no pair is in flight.
// One pair is taken every cycle while the output does not stall; the depth
// is set by the longest path, the power-law one: the distance root (32
// stages) and three chained dividers (80 stages each, one quotient bit per
// stage).
// Reset clears the valid bits of the pipeline and loads the register
// defaults; no word is taken while reset is high. When the receiver holds
// tready low with a result waiting, the whole pipeline freezes and s_tready
// drops; nothing is lost or repeated and flow resumes in the cycle that the
// result is taken.
module soft_disk_pair_force_unit import sdpf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // pos_x_first, pos_y_first, pos_x_second, pos_y_second
  input  logic [127:0]     s_tdata,
  // class_first, class_second
  input  logic [1:0]       s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  // force_x, force_y, force_scalar, pair_virial
  output logic [191:0]     m_tdata,
  // in_contact
  output logic [0:0]       m_tuser,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [31:0]      wr_data
);

  // Stage numbers of the main events.
  localparam int S_FRONT = 5;
  localparam int S_ROOT  = S_FRONT + SQRT_STEPS;
  localparam int S_QUO   = S_ROOT + DIV_STEPS;
  localparam int S_HS    = S_QUO + 1 + SQRT_STEPS;
  localparam int S_HP    = S_HS + 2;
  localparam int S_HQ    = S_HP + DIV_STEPS;
  localparam int S_VQ    = S_QUO + DIV_STEPS;
  localparam int S_V2    = S_VQ + 1 + QMUL_LAT;
  localparam int S_V10   = S_V2 + 3 * QMUL_LAT;
  localparam int S_PA    = S_V10 + 2;
  localparam int S_PQ    = S_PA + DIV_STEPS;
  localparam int S_OUT   = S_PQ + 3;

  // Delay depths.
  localparam int TAIL_D = S_PQ - S_QUO;
  localparam int U_D    = S_VQ - S_QUO;
  localparam int PN_D   = S_V10 - S_VQ - 4;
  localparam int V2_D   = 2 * QMUL_LAT;
  localparam int VH_D   = S_PQ - S_HP - 1;
  localparam int GH_D   = S_PQ - S_HQ;
  localparam int PS_D   = S_PQ - S_PA;

  typedef struct packed {
    logic [31:0] sigma;
    logic [31:0] ax;
    logic [31:0] ay;
    logic        negx;
    logic        negy;
    logic        contact;
  } side_t;

  typedef struct packed {
    logic [31:0] sigma;
    logic [31:0] r;
    logic        negx;
    logic        negy;
    logic        contact;
  } mid_t;

  typedef struct packed {
    logic [31:0] sigma;
    logic [31:0] r;
    logic        negx;
    logic        negy;
    logic        contact;
    logic [32:0] ux;
    logic [32:0] uy;
  } tail_t;

  typedef struct packed {
    logic [30:0] t;
    logic [31:0] u;
  } hdly_t;

  typedef struct packed {
    logic [31:0] posl;
    logic [32:0] neg;
  } pn_t;

  typedef struct packed {
    logic        sat;
    logic [56:0] a;
  } ps_t;

  // Configuration registers.
  logic [31:0] box_length;
  logic        potential_mode;
  logic [31:0] diameter_small_small;
  logic [31:0] diameter_mixed;
  logic [31:0] diameter_large_large;

  // Flow control.
  logic             en;
  logic [S_OUT:1]   vld;

  // Front stages.
  logic signed [33:0] f1_dx, f1_dy;
  logic [31:0]        f1_sigma;
  logic signed [34:0] f2_dx, f2_dy;
  logic [31:0]        f2_sigma;
  logic [31:0]        f3_ax, f3_ay, f3_sigma;
  logic               f3_negx, f3_negy, f3_far;
  logic [63:0]        f4_axx, f4_ayy, f4_s2;
  logic [31:0]        f4_ax, f4_ay, f4_sigma;
  logic               f4_negx, f4_negy, f4_far;
  logic [63:0]        f5_r2;
  side_t              f5_side;
  logic [64:0]        r2_sum;
  logic signed [34:0] half_s, len_s;
  logic [31:0]        sigma_sel;
  logic [34:0]        mag_x, mag_y;

  side_t side_dly [SQRT_STEPS];
  side_t s_root;
  logic [31:0] root_r;

  mid_t  mid_dly [DIV_STEPS];
  mid_t  s_quo;
  logic [NUM_W-1:0] quo_u, quo_x, quo_y;
  logic [31:0] u_q;
  tail_t tail_in;
  tail_t tail_dly [TAIL_D];

  // Hertzian branch.
  logic [30:0] h_t;
  logic [31:0] h_u;
  hdly_t       hdly [SQRT_STEPS];
  logic [31:0] h_s;
  logic [61:0] h_ts;
  logic [31:0] h_u2, h_u3;
  logic [30:0] h_p;
  logic [62:0] h_pu;
  logic [32:0] vh_dly [VH_D];
  logic [NUM_W-1:0] quo_h;
  logic [58:0] gh_dly [GH_D];

  // Power-law branch.
  logic [31:0]      udly [U_D];
  logic [NUM_W-1:0] quo_v;
  logic [POW_W-1:0] p_v, v2, v4, v8, v10;
  logic [POW_W-1:0] v2d [V2_D];
  logic [63:0]      p_uu, p_u4p, p_ku4, p_ku2;
  logic [31:0]      p_u2a;
  pn_t              p_pn;
  pn_t              pn_dly [PN_D];
  logic [56:0]      pos_sum, p_a;
  ps_t              p_ps;
  ps_t              ps_dly [PS_D];
  logic [NUM_W-1:0] quo_p;
  logic [31:0]      r_pa;

  // Output stages.
  logic [46:0] m_f, m_vir;
  tail_t       m_tail;
  logic [46:0] q_f, q_vir;
  logic        q_negx, q_negy, q_contact, q_dir;
  logic [55:0] ppx_h, ppy_h;
  logic [56:0] ppx_l, ppy_l;
  logic [79:0] prod_x, prod_y;
  logic [47:0] mag_fx, mag_fy;
  logic        out_contact;
  logic [47:0] out_fx, out_fy, out_fs, out_vir;

  // Minimum-image wrap of one raw separation.
  function automatic logic signed [34:0] wrap(input logic signed [33:0] d,
                                              input logic signed [34:0] half,
                                              input logic signed [34:0] len);
    logic signed [34:0] e;
    e = {d[33], d};
    if (e >= half) begin
      return e - len;
    end else if (e < -half) begin
      return e + len;
    end
    return e;
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_length           <= BOX_LENGTH_RST;
      potential_mode       <= 1'b0;
      diameter_small_small <= DIAM_SMALL_RST;
      diameter_mixed       <= DIAM_MIXED_RST;
      diameter_large_large <= DIAM_LARGE_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BOX_LENGTH: box_length           <= wr_data;
        REG_POTENTIAL:  potential_mode       <= wr_data[0];
        REG_DIAM_SMALL: diameter_small_small <= wr_data;
        REG_DIAM_MIXED: diameter_mixed       <= wr_data;
        REG_DIAM_LARGE: diameter_large_large <= wr_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register can take a word.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !rst;
  assign m_tvalid = vld[S_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[S_OUT-1:1], s_tvalid};
    end
  end

  // Front end: wrap, magnitude, squares and the contact test.
  assign half_s    = $signed({4'b0, box_length[31:1]});
  assign len_s     = $signed({3'b0, box_length});
  assign sigma_sel = (s_tuser[0] != s_tuser[1]) ? diameter_mixed :
                     (s_tuser[0] ? diameter_large_large : diameter_small_small);
  assign mag_x     = f2_dx[34] ? 35'(-f2_dx) : f2_dx;
  assign mag_y     = f2_dy[34] ? 35'(-f2_dy) : f2_dy;
  assign r2_sum    = {1'b0, f4_axx} + {1'b0, f4_ayy};

  always_ff @(posedge clk) begin
    if (en) begin
      f1_dx    <= $signed({2'b00, s_tdata[95:64]}) - $signed({2'b00, s_tdata[31:0]});
      f1_dy    <= $signed({2'b00, s_tdata[127:96]}) - $signed({2'b00, s_tdata[63:32]});
      f1_sigma <= sigma_sel;

      f2_dx    <= wrap(f1_dx, half_s, len_s);
      f2_dy    <= wrap(f1_dy, half_s, len_s);
      f2_sigma <= f1_sigma;

      f3_ax    <= mag_x[31:0];
      f3_ay    <= mag_y[31:0];
      f3_far   <= (|mag_x[34:32]) || (|mag_y[34:32]);
      f3_negx  <= f2_dx[34];
      f3_negy  <= f2_dy[34];
      f3_sigma <= f2_sigma;

      f4_axx   <= f3_ax * f3_ax;
      f4_ayy   <= f3_ay * f3_ay;
      f4_s2    <= f3_sigma * f3_sigma;
      f4_ax    <= f3_ax;
      f4_ay    <= f3_ay;
      f4_negx  <= f3_negx;
      f4_negy  <= f3_negy;
      f4_far   <= f3_far;
      f4_sigma <= f3_sigma;

      f5_r2            <= r2_sum[63:0];
      f5_side.sigma    <= f4_sigma;
      f5_side.ax       <= f4_ax;
      f5_side.ay       <= f4_ay;
      f5_side.negx     <= f4_negx;
      f5_side.negy     <= f4_negy;
      f5_side.contact  <= !f4_far && (r2_sum < {1'b0, f4_s2});
    end
  end

  // Distance root.
  sdpf_sqrt u_root (
    .clk      (clk),
    .en       (en),
    .radicand (f5_r2),
    .root     (root_r)
  );

  assign s_root = side_dly[SQRT_STEPS-1];

  // Reduced distance and the two direction cosines, divided side by side.
  sdpf_div u_div_u (
    .clk (clk),
    .en  (en),
    .num ({16'b0, root_r, 32'b0}),
    .den ({32'b0, s_root.sigma}),
    .quo (quo_u)
  );

  sdpf_div u_div_x (
    .clk (clk),
    .en  (en),
    .num ({16'b0, s_root.ax, 32'b0}),
    .den ({32'b0, root_r}),
    .quo (quo_x)
  );

  sdpf_div u_div_y (
    .clk (clk),
    .en  (en),
    .num ({16'b0, s_root.ay, 32'b0}),
    .den ({32'b0, root_r}),
    .quo (quo_y)
  );

  assign s_quo = mid_dly[DIV_STEPS-1];
  assign u_q   = quo_u[31:0];

  always_comb begin
    tail_in.sigma   = s_quo.sigma;
    tail_in.r       = s_quo.r;
    tail_in.negx    = s_quo.negx;
    tail_in.negy    = s_quo.negy;
    tail_in.contact = s_quo.contact;
    tail_in.ux      = quo_x[32:0];
    tail_in.uy      = quo_y[32:0];
  end

  // Side data that travels alongside the long units.
  always_ff @(posedge clk) begin
    if (en) begin
      side_dly[0] <= f5_side;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        side_dly[k] <= side_dly[k-1];
      end
      mid_dly[0] <= '{sigma: s_root.sigma, r: root_r, negx: s_root.negx,
                      negy: s_root.negy, contact: s_root.contact};
      for (int k = 1; k < DIV_STEPS; k++) begin
        mid_dly[k] <= mid_dly[k-1];
      end
      tail_dly[0] <= tail_in;
      for (int k = 1; k < TAIL_D; k++) begin
        tail_dly[k] <= tail_dly[k-1];
      end
    end
  end

  // Hertzian branch: t = 1 - u, p = t^1.5, then scale by the diameter.
  sdpf_sqrt u_root_h (
    .clk      (clk),
    .en       (en),
    .radicand ({3'b0, h_t, 30'b0}),
    .root     (h_s)
  );

  sdpf_div u_div_h (
    .clk (clk),
    .en  (en),
    .num ({21'b0, h_p, 28'b0}),
    .den ({32'b0, tail_dly[S_HP-S_QUO-1].sigma}),
    .quo (quo_h)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      h_t <= 31'h4000_0000 - {1'b0, u_q[31:2]};
      h_u <= u_q;
      hdly[0] <= '{t: h_t, u: h_u};
      for (int k = 1; k < SQRT_STEPS; k++) begin
        hdly[k] <= hdly[k-1];
      end
      h_ts <= hdly[SQRT_STEPS-1].t * h_s[30:0];
      h_u2 <= hdly[SQRT_STEPS-1].u;
      h_p  <= h_ts[60:30];
      h_u3 <= h_u2;
      h_pu <= h_p * h_u3;
      vh_dly[0] <= h_pu[62:30];
      for (int k = 1; k < VH_D; k++) begin
        vh_dly[k] <= vh_dly[k-1];
      end
      gh_dly[0] <= quo_h[58:0];
      for (int k = 1; k < GH_D; k++) begin
        gh_dly[k] <= gh_dly[k-1];
      end
    end
  end

  // Power-law branch: inverse distance and its powers.
  sdpf_div u_div_v (
    .clk (clk),
    .en  (en),
    .num (NUM_W'(1) << 62),
    .den ({32'b0, u_q}),
    .quo (quo_v)
  );

  sdpf_qmul u_mul_v2 (.clk(clk), .en(en), .a(p_v), .b(p_v), .y(v2));
  sdpf_qmul u_mul_v4 (.clk(clk), .en(en), .a(v2), .b(v2), .y(v4));
  sdpf_qmul u_mul_v8 (.clk(clk), .en(en), .a(v4), .b(v4), .y(v8));
  sdpf_qmul u_mul_v10 (.clk(clk), .en(en), .a(v8), .b(v2d[V2_D-1]), .y(v10));

  assign pos_sum = {1'b0, v10, 5'b0} + {3'b0, v10, 3'b0}
                 + {25'b0, pn_dly[PN_D-1].posl};
  assign r_pa    = tail_dly[S_PA-S_QUO-2].r;

  always_ff @(posedge clk) begin
    if (en) begin
      udly[0] <= u_q;
      for (int k = 1; k < U_D; k++) begin
        udly[k] <= udly[k-1];
      end
      // Below 2^-20 of the diameter the inverse passes the cap.
      p_v   <= (udly[U_D-1][31:12] == '0) ? POW_CAP : quo_v[POW_W-1:0];
      p_uu  <= udly[U_D-1] * udly[U_D-1];
      p_u4p <= p_uu[63:32] * p_uu[63:32];
      p_u2a <= p_uu[63:32];
      p_ku4 <= K_CUBE_Q32 * p_u4p[63:32];
      p_ku2 <= K_LIN_Q31 * p_u2a;
      p_pn.posl <= p_ku4[63:32];
      p_pn.neg  <= p_ku2[63:31];
      pn_dly[0] <= p_pn;
      for (int k = 1; k < PN_D; k++) begin
        pn_dly[k] <= pn_dly[k-1];
      end
      v2d[0] <= v2;
      for (int k = 1; k < V2_D; k++) begin
        v2d[k] <= v2d[k-1];
      end
      p_a <= (pos_sum > {24'b0, pn_dly[PN_D-1].neg}) ?
             pos_sum - {24'b0, pn_dly[PN_D-1].neg} : '0;
      // A quotient of 2^22 or more, or a zero distance, saturates.
      p_ps.sat <= (p_a >= {3'b0, r_pa, 22'b0});
      p_ps.a   <= p_a;
      ps_dly[0] <= p_ps;
      for (int k = 1; k < PS_D; k++) begin
        ps_dly[k] <= ps_dly[k-1];
      end
    end
  end

  sdpf_div u_div_p (
    .clk (clk),
    .en  (en),
    .num ({p_ps.a[53:0], 26'b0}),
    .den ({32'b0, tail_dly[S_PA-S_QUO-1].r}),
    .quo (quo_p)
  );

  // Merge the branches, project onto the axes and apply the sign.
  assign prod_x = {ppx_h, 24'b0} + {23'b0, ppx_l};
  assign prod_y = {ppy_h, 24'b0} + {23'b0, ppy_l};
  assign mag_fx = prod_x[79:32];
  assign mag_fy = prod_y[79:32];

  always_ff @(posedge clk) begin
    if (en) begin
      if (potential_mode) begin
        m_f   <= ps_dly[PS_D-1].sat ? MAX47 : sat47(quo_p);
        m_vir <= sat47({23'b0, ps_dly[PS_D-1].a});
      end else begin
        m_f   <= sat47({21'b0, gh_dly[GH_D-1]});
        m_vir <= sat47({47'b0, vh_dly[VH_D-1]});
      end
      m_tail <= tail_dly[TAIL_D-1];

      ppx_h     <= m_f[46:24] * m_tail.ux;
      ppx_l     <= m_f[23:0] * m_tail.ux;
      ppy_h     <= m_f[46:24] * m_tail.uy;
      ppy_l     <= m_f[23:0] * m_tail.uy;
      q_f       <= m_f;
      q_vir     <= m_vir;
      q_negx    <= m_tail.negx;
      q_negy    <= m_tail.negy;
      q_contact <= m_tail.contact;
      q_dir     <= m_tail.contact && (m_tail.r != '0);

      out_contact <= q_contact;
      out_fx  <= !q_dir ? '0 : (q_negx ? 48'd0 - mag_fx : mag_fx);
      out_fy  <= !q_dir ? '0 : (q_negy ? 48'd0 - mag_fy : mag_fy);
      out_fs  <= q_contact ? {1'b0, q_f} : '0;
      out_vir <= q_contact ? {1'b0, q_vir} : '0;
    end
  end

  assign m_tdata = {out_vir, out_fs, out_fy, out_fx};
  assign m_tuser = out_contact;

  // A pair in contact has a distance below its diameter.
  assert property (@(posedge clk) disable iff (rst)
    vld[S_ROOT] && s_root.contact |-> root_r < s_root.sigma)
    else $error("contact pair with root not below diameter");

  // The Hertzian overlap power never exceeds one.
  assert property (@(posedge clk) disable iff (rst)
    vld[S_HP] |-> h_p <= 31'h4000_0000)
    else $error("Hertzian overlap power above one");

  // A result without contact carries no force.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("force given for a pair out of contact");

  // Reset empties the pipeline.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid straight after reset");

endmodule
